[rtl/core/pscp_pkg.sv]
`default_nettype none
package pscp_pkg;

  localparam int MAX_POSITIONS = 1024;
  localparam int ALPHABET_SIZE = 256;
  localparam int COUNT_BITS    = 20;
  localparam int GROUP_SIZE    = 64;

  localparam int POS_W  = $clog2(MAX_POSITIONS);
  localparam int LEN_W  = POS_W + 1;
  localparam int SYM_W  = $clog2(ALPHABET_SIZE);
  localparam int GIDX_W = $clog2(GROUP_SIZE);
  localparam int GRP_W  = SYM_W - GIDX_W;
  localparam int ADDR_W = POS_W + SYM_W;
  localparam int TOT_W  = 20;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [TOT_W-1:0]      TOT_MAX   = '1;
  localparam logic [LEN_W-1:0]      LEN_MAX   = LEN_W'(MAX_POSITIONS);

  // item kinds
  localparam logic [1:0] KIND_SYMBOL = 2'd0;
  localparam logic [1:0] KIND_EMPTY  = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_ENTRY  = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BEYOND = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [SYM_W-1:0] symbol;
    logic             eos;
    logic [9:0]       position;
    logic [GRP_W-1:0] group;
  } cmd_t;

endpackage
`default_nettype wire

[rtl/core/pscp_front.sv]
`default_nettype none
module pscp_front
  import pscp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_kind,
  input  wire logic [7:0] in_symbol,
  input  wire logic       in_end_of_sequence,
  input  wire logic [9:0] in_position,
  input  wire logic [1:0] in_group,
  input  wire logic       back_clearing,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_data,
  output logic            busy
);

  logic front_v_r, front_v_nxt;
  cmd_t cmd_r;
  logic accept;

  // hold off while the word cannot move on or the store is being swept
  assign busy   = (front_v_r && q_full) || back_clearing;
  assign accept = start && !busy;
  assign q_push = front_v_r && !q_full;
  assign q_data = cmd_r;

  always_comb begin
    front_v_nxt = accept || (front_v_r && !q_push);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
  end

  // capture and classify the word; only symbols carry an end mark
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.kind     <= in_kind;
      cmd_r.symbol   <= in_symbol;
      cmd_r.eos      <= (in_kind == KIND_SYMBOL) && in_end_of_sequence;
      cmd_r.position <= in_position;
      cmd_r.group    <= in_group;
    end
  end

endmodule
`default_nettype wire

[rtl/core/pscp_queue.sv]
`default_nettype none
module pscp_queue
  import pscp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_data,
  input  wire logic pop,
  output logic      full,
  output logic      valid,
  output cmd_t      head
);

  cmd_t slot_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = slot_r[rp_r];

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_data;
  end

endmodule
`default_nettype wire

[rtl/core/pscp_back.sv]
`default_nettype none
module pscp_back
  import pscp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire cmd_t        q_head,
  output logic             q_pop,
  output logic             clearing,
  output logic             out_valid,
  output logic [7:0]       out_symbol_out,
  output logic [19:0]      out_count,
  output logic [1:0]       out_status,
  output logic             out_last,
  output logic [10:0]      out_min_length,
  output logic [19:0]      out_sequence_total
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLR   = 3'd1;
  localparam logic [2:0] S_SYMWR = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [COUNT_BITS-1:0] mem [MAX_POSITIONS*ALPHABET_SIZE];
  logic [COUNT_BITS-1:0] mem_q;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [LEN_W-1:0]  cur_r, cur_nxt;
  logic [LEN_W-1:0]  short_r, short_nxt;
  logic [TOT_W-1:0]  seq_r, seq_nxt;
  logic [ADDR_W-1:0] wa_r, wa_nxt;
  logic [POS_W-1:0]  spos_r, spos_nxt;
  logic [GRP_W-1:0]  sgrp_r, sgrp_nxt;
  logic [GIDX_W-1:0] iss_r, iss_nxt;
  logic [GIDX_W-1:0] chk_r, chk_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [SYM_W-1:0]  pend_s_r, pend_s_nxt;
  logic [COUNT_BITS-1:0] pend_c_r, pend_c_nxt;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  logic              o_v;
  logic [SYM_W-1:0]  o_s;
  logic [COUNT_BITS-1:0] o_c;
  logic [1:0]        o_st;
  logic              o_l;

  logic [LEN_W-1:0]  min_len, new_pos;

  assign clearing = (state_r == S_CLR);
  assign min_len  = (seq_r != '0) ? short_r : '0;
  assign new_pos  = (cur_r < LEN_MAX) ? cur_r + 1'b1 : cur_r;

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    cur_nxt    = cur_r;
    short_nxt  = short_r;
    seq_nxt    = seq_r;
    wa_nxt     = wa_r;
    spos_nxt   = spos_r;
    sgrp_nxt   = sgrp_r;
    iss_nxt    = iss_r;
    chk_nxt    = chk_r;
    pend_v_nxt = pend_v_r;
    pend_s_nxt = pend_s_r;
    pend_c_nxt = pend_c_r;
    q_pop   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = wa_r;
    wr_data = '0;
    o_v  = 1'b0;
    o_s  = '0;
    o_c  = '0;
    o_st = ST_ENTRY;
    o_l  = 1'b0;
    unique case (state_r)
      // take the next word and dispatch on its kind
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_head.kind)
            KIND_SYMBOL: begin
              if (cur_r < LEN_MAX) begin
                rd_en     = 1'b1;
                rd_addr   = {cur_r[POS_W-1:0], q_head.symbol};
                wa_nxt    = rd_addr;
                state_nxt = S_SYMWR;
              end
              cur_nxt = new_pos;
              if (q_head.eos) begin
                if (new_pos < short_r) short_nxt = new_pos;
                if (seq_r != TOT_MAX) seq_nxt = seq_r + 1'b1;
                cur_nxt = '0;
              end
            end
            KIND_EMPTY: begin
              if (cur_r < short_r) short_nxt = cur_r;
              if (seq_r != TOT_MAX) seq_nxt = seq_r + 1'b1;
              cur_nxt = '0;
            end
            KIND_CLEAR: begin
              cur_nxt   = '0;
              short_nxt = LEN_MAX;
              seq_nxt   = '0;
              clr_nxt   = '0;
              state_nxt = S_CLR;
            end
            default: begin
              if ({1'b0, q_head.position} >= min_len) begin
                o_v  = 1'b1;
                o_st = ST_BEYOND;
                o_l  = 1'b1;
              end else begin
                spos_nxt   = q_head.position[POS_W-1:0];
                sgrp_nxt   = q_head.group;
                rd_en      = 1'b1;
                rd_addr    = {q_head.position[POS_W-1:0], q_head.group, GIDX_W'(0)};
                chk_nxt    = '0;
                iss_nxt    = GIDX_W'(1);
                pend_v_nxt = 1'b0;
                state_nxt  = S_SCAN;
              end
            end
          endcase
        end
      end
      // sweep the store to zero, one entry a cycle
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      // write back the saturating increment
      S_SYMWR: begin
        wr_en     = 1'b1;
        wr_data   = (mem_q != COUNT_MAX) ? mem_q + 1'b1 : mem_q;
        state_nxt = S_IDLE;
      end
      // check one entry, issue the next read; keep one hit pending for last
      S_SCAN: begin
        if (mem_q != '0) begin
          if (pend_v_r) begin
            o_v = 1'b1;
            o_s = pend_s_r;
            o_c = pend_c_r;
          end
          pend_v_nxt = 1'b1;
          pend_s_nxt = {sgrp_r, chk_r};
          pend_c_nxt = mem_q;
        end
        if (chk_r == '1) begin
          state_nxt = S_FLUSH;
        end else begin
          rd_en   = 1'b1;
          rd_addr = {spos_r, sgrp_r, iss_r};
          chk_nxt = iss_r;
          iss_nxt = iss_r + 1'b1;
        end
      end
      // emit the final hit, or the empty-group result
      S_FLUSH: begin
        o_v = 1'b1;
        o_l = 1'b1;
        if (pend_v_r) begin
          o_s = pend_s_r;
          o_c = pend_c_r;
        end else begin
          o_st = ST_EMPTY;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_r     <= '0;
      cur_r     <= '0;
      short_r   <= LEN_MAX;
      seq_r     <= '0;
      pend_v_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      cur_r     <= cur_nxt;
      short_r   <= short_nxt;
      seq_r     <= seq_nxt;
      pend_v_r  <= pend_v_nxt;
      out_valid <= o_v;
    end
  end

  // datapath registers and the result word
  always_ff @(posedge clk) begin
    wa_r     <= wa_nxt;
    spos_r   <= spos_nxt;
    sgrp_r   <= sgrp_nxt;
    iss_r    <= iss_nxt;
    chk_r    <= chk_nxt;
    pend_s_r <= pend_s_nxt;
    pend_c_r <= pend_c_nxt;
    out_symbol_out     <= o_s;
    out_count          <= 20'(o_c);
    out_status         <= o_st;
    out_last           <= o_l;
    out_min_length     <= min_len;
    out_sequence_total <= seq_r;
  end

  // count store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) mem_q <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[rtl/core/position_symbol_count_profile.sv]
// A read beyond the profile answers in the cycle after it leaves the queue; an in-range read
// holds the back while it scans every entry of the group, results one per cycle at most, the
// last from the flush state. Symbol words in range take a read-modify-write, empty words no
// store access; words run one after another. The store has one read and one write port. A
// clear word and reset run a sweep of all 262144 entries, one entry per cycle, with busy high.
// Reset: synchronous active-low; results are strobed by out_valid and cannot be stalled.
`default_nettype none
module position_symbol_count_profile
  import pscp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [7:0]  in_symbol,
  input  wire logic        in_end_of_sequence,
  input  wire logic [9:0]  in_position,
  input  wire logic [1:0]  in_group,
  output logic             out_valid,
  output logic [7:0]       out_symbol_out,
  output logic [19:0]      out_count,
  output logic [1:0]       out_status,
  output logic             out_last,
  output logic [10:0]      out_min_length,
  output logic [19:0]      out_sequence_total
);

  logic q_push, q_full, q_valid, q_pop, clearing;
  cmd_t q_in, q_head;

  pscp_front u_front (
    .clk, .rst_n, .start,
    .in_kind, .in_symbol, .in_end_of_sequence, .in_position, .in_group,
    .back_clearing(clearing),
    .q_full, .q_push, .q_data(q_in), .busy
  );

  pscp_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .pop(q_pop),
    .full(q_full), .valid(q_valid), .head(q_head)
  );

  pscp_back u_back (
    .clk, .rst_n, .q_valid, .q_head, .q_pop, .clearing,
    .out_valid, .out_symbol_out, .out_count, .out_status, .out_last,
    .out_min_length, .out_sequence_total
  );

endmodule
`default_nettype wire
